### hdl/bia_pkg.sv
// Shared constants, codes and types of the bitmap handle allocator.
package bia_pkg;

	localparam int WORD_BITS    = 32;
	localparam int MAP_WORDS_DEF = 32;
	localparam int HANDLE_WORDS = 32;
	localparam int HANDLE_W     = 10;
	localparam int WORDS_W      = 6;
	localparam int HINT_W       = 11;
	localparam int WPTR_W       = 5;
	localparam int BIT_W        = 5;
	localparam int FUNC_W       = 3;
	localparam int STATUS_W     = 2;

	localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_RELEASE   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MARK_USED = 3'd2;
	localparam logic [FUNC_W-1:0] FN_MARK_FREE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_TEST      = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	localparam logic [WORDS_W-1:0] WORDS_RESET = 6'd32;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BIT,
		S_SCAN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic              found;
		logic [BIT_W-1:0]  pos;
	} zero_hit_t;

	// lowest set bit of a candidate vector
	function automatic zero_hit_t lowest_set(input logic [WORD_BITS-1:0] v);
		zero_hit_t r;
		r.found = |v;
		r.pos   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.pos = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### hdl/bitmap_id_allocator.sv
// Top level of the bitmap handle allocator: control, hint and result registers.
//
// Usage: one request word on func/index (in_valid/in_ready) gives exactly one
// result word on handle/bit_value/status (out_valid/out_ready). The map words
// live in one RAM with a registered read; a valid bit per word makes an unwritten
// word read as free, so no clearing pass is needed.
// One request is in flight at a time; in_ready is high only while idle and cfg_valid is low.
// Unknown funcs, range errors and an empty map go straight to the result.
// Release and mark read the word, write it back modified and give the result;
// test reads the word and gives the bit. Allocate reads one word per cycle
// starting at the hint's word until it finds a free bit or has visited every
// word in use, in which case it gives ST_FULL.
// A result waits in the output register while out_ready is low; the next
// request is still accepted and finishes into a holding register behind it.
// Reset (arst_n low) sets words_in_use to 32 and empties the map and the hint.
// A write on cfg_valid/cfg_ready (accepted while idle) sets words_in_use and
// empties the map and the hint in the same cycle.
module bitmap_id_allocator #(
	parameter int MAP_WORDS = bia_pkg::MAP_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bia_pkg::FUNC_W-1:0]       func,
	input  logic [bia_pkg::HANDLE_W-1:0]     index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bia_pkg::HANDLE_W-1:0]     handle,
	output logic                             bit_value,
	output logic [bia_pkg::STATUS_W-1:0]     status,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bia_pkg::WORDS_W-1:0]      words_in_use
);

	localparam int USED_WORDS = (MAP_WORDS < bia_pkg::HANDLE_WORDS) ?
		MAP_WORDS : bia_pkg::HANDLE_WORDS;
	localparam int AW = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
	localparam int WB = bia_pkg::WORD_BITS;

	bia_pkg::state_t state_q, state_d;

	logic [bia_pkg::WORDS_W-1:0]  words_q;
	logic [USED_WORDS-1:0]        vld_q;
	logic [bia_pkg::HINT_W-1:0]   hint_q;

	logic [bia_pkg::FUNC_W-1:0]   op_q;
	logic [bia_pkg::HANDLE_W-1:0] idx_q;

	logic [bia_pkg::WPTR_W-1:0]   rp_q;
	logic [bia_pkg::BIT_W-1:0]    sb_q;
	logic [bia_pkg::WORDS_W-1:0]  iss_q;

	logic                         scan_v_s1;
	logic                         first_s1;
	logic                         last_s1;
	logic [bia_pkg::WPTR_W-1:0]   word_s1;
	logic                         wvld_s1;

	logic [bia_pkg::HANDLE_W-1:0] res_handle_q;
	logic                         res_bit_q;
	logic [bia_pkg::STATUS_W-1:0] res_status_q;

	logic                         out_valid_q;
	logic [bia_pkg::HANDLE_W-1:0] handle_q;
	logic                         bit_value_q;
	logic [bia_pkg::STATUS_W-1:0] status_q;

	logic [bia_pkg::WORDS_W-1:0]  act;
	logic [bia_pkg::HINT_W-1:0]   total;
	logic                         in_acc;
	logic                         cfg_acc;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [WB-1:0]                ram_wdata;
	logic [AW-1:0]                ram_raddr;
	logic [WB-1:0]                ram_rdata;
	logic [WB-1:0]                cur_word;

	logic [bia_pkg::HINT_W-1:0]   start;
	logic [WB-1:0]                first_mask;
	logic [WB-1:0]                scan_mask;
	bia_pkg::zero_hit_t           hit;
	logic                         issue;
	logic                         scan_done;
	logic [bia_pkg::HANDLE_W-1:0] found_handle;
	logic [WB-1:0]                bit_onehot;

	logic                         set_res;
	logic [bia_pkg::HANDLE_W-1:0] res_handle_d;
	logic                         res_bit_d;
	logic [bia_pkg::STATUS_W-1:0] res_status_d;
	logic                         hint_we;
	logic [bia_pkg::HINT_W-1:0]   hint_d;
	logic                         scan_start;

	bia_ram #(
		.WIDTH (WB),
		.DEPTH (USED_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign act = (words_q > bia_pkg::WORDS_W'(USED_WORDS)) ?
		bia_pkg::WORDS_W'(USED_WORDS) : words_q;
	assign total = {act, 5'b0};

	assign in_ready  = (state_q == bia_pkg::S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == bia_pkg::S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign cur_word   = wvld_s1 ? ram_rdata : '0;
	assign start      = (hint_q < total) ? hint_q : '0;
	assign first_mask = {WB{1'b1}} << sb_q;
	assign scan_mask  = (first_s1 ? first_mask : {WB{1'b1}}) &
		(last_s1 ? ~first_mask : {WB{1'b1}});
	assign hit        = bia_pkg::lowest_set(~cur_word & scan_mask);
	assign scan_done  = scan_v_s1 && (hit.found || last_s1);
	assign issue      = (state_q == bia_pkg::S_SCAN) && (iss_q <= act) && !scan_done;
	assign found_handle = {word_s1, hit.pos};
	assign bit_onehot = {{(WB-1){1'b0}}, 1'b1} << idx_q[bia_pkg::BIT_W-1:0];

	always_comb begin
		state_d      = state_q;
		ram_raddr    = AW'(rp_q);
		ram_we       = 1'b0;
		ram_waddr    = AW'(idx_q[bia_pkg::HANDLE_W-1:bia_pkg::BIT_W]);
		ram_wdata    = cur_word;
		set_res      = 1'b0;
		res_handle_d = index;
		res_bit_d    = 1'b0;
		res_status_d = bia_pkg::ST_OK;
		hint_we      = 1'b0;
		hint_d       = hint_q;
		scan_start   = 1'b0;
		case (state_q)
			bia_pkg::S_IDLE: begin
				ram_raddr = AW'(index[bia_pkg::HANDLE_W-1:bia_pkg::BIT_W]);
				if (in_acc) begin
					if (func == bia_pkg::FN_ALLOC) begin
						if (total == '0) begin
							set_res      = 1'b1;
							res_handle_d = '0;
							res_status_d = bia_pkg::ST_FULL;
							state_d      = bia_pkg::S_OUT;
						end else begin
							scan_start = 1'b1;
							state_d    = bia_pkg::S_SCAN;
						end
					end else if (func inside {[bia_pkg::FN_RELEASE:bia_pkg::FN_TEST]}) begin
						if ({1'b0, index} >= total) begin
							set_res      = 1'b1;
							res_status_d = bia_pkg::ST_RANGE;
							state_d      = bia_pkg::S_OUT;
						end else begin
							state_d = bia_pkg::S_BIT;
						end
					end else begin
						set_res = 1'b1;
						state_d = bia_pkg::S_OUT;
					end
				end
			end
			bia_pkg::S_BIT: begin
				set_res      = 1'b1;
				res_handle_d = idx_q;
				state_d      = bia_pkg::S_OUT;
				case (op_q)
					bia_pkg::FN_RELEASE: begin
						ram_we    = 1'b1;
						ram_wdata = cur_word & ~bit_onehot;
						if ({1'b0, idx_q} < hint_q) begin
							hint_we = 1'b1;
							hint_d  = {1'b0, idx_q};
						end
					end
					bia_pkg::FN_MARK_USED: begin
						ram_we    = 1'b1;
						ram_wdata = cur_word | bit_onehot;
					end
					bia_pkg::FN_MARK_FREE: begin
						ram_we    = 1'b1;
						ram_wdata = cur_word & ~bit_onehot;
					end
					default: begin
						res_bit_d = |(cur_word & bit_onehot);
					end
				endcase
			end
			bia_pkg::S_SCAN: begin
				ram_waddr = AW'(word_s1);
				ram_wdata = cur_word | ({{(WB-1){1'b0}}, 1'b1} << hit.pos);
				if (scan_v_s1 && hit.found) begin
					ram_we       = 1'b1;
					hint_we      = 1'b1;
					hint_d       = {1'b0, found_handle} + bia_pkg::HINT_W'(1);
					set_res      = 1'b1;
					res_handle_d = found_handle;
					state_d      = bia_pkg::S_OUT;
				end else if (scan_done) begin
					set_res      = 1'b1;
					res_handle_d = '0;
					res_status_d = bia_pkg::ST_FULL;
					state_d      = bia_pkg::S_OUT;
				end
			end
			bia_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = bia_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bia_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bia_pkg::S_IDLE;
			words_q     <= bia_pkg::WORDS_RESET;
			vld_q       <= '0;
			hint_q      <= '0;
			scan_v_s1   <= 1'b0;
			iss_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				words_q <= words_in_use;
				vld_q   <= '0;
				hint_q  <= '0;
			end else begin
				if (ram_we) begin
					vld_q[ram_waddr] <= 1'b1;
				end
				if (hint_we) begin
					hint_q <= hint_d;
				end
			end
			scan_v_s1 <= issue;
			if (scan_start) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + bia_pkg::WORDS_W'(1);
			end
			if (state_q == bia_pkg::S_OUT && state_d == bia_pkg::S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wvld_s1 <= vld_q[ram_raddr];
		if (in_acc) begin
			op_q  <= func;
			idx_q <= index;
		end
		if (scan_start) begin
			rp_q <= start[bia_pkg::HINT_W-2:bia_pkg::BIT_W];
			sb_q <= start[bia_pkg::BIT_W-1:0];
		end else if (issue) begin
			rp_q <= ({1'b0, rp_q} == act - bia_pkg::WORDS_W'(1)) ? '0 :
				rp_q + bia_pkg::WPTR_W'(1);
		end
		if (issue) begin
			first_s1 <= (iss_q == '0);
			last_s1  <= (iss_q == act);
			word_s1  <= rp_q;
		end
		if (set_res) begin
			res_handle_q <= res_handle_d;
			res_bit_q    <= res_bit_d;
			res_status_q <= res_status_d;
		end
		if (state_q == bia_pkg::S_OUT && state_d == bia_pkg::S_IDLE) begin
			handle_q    <= res_handle_q;
			bit_value_q <= res_bit_q;
			status_q    <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign handle    = handle_q;
	assign bit_value = bit_value_q;
	assign status    = status_q;

	a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_v_s1 |-> (state_q == bia_pkg::S_SCAN))
		else $error("scan stage active outside the scan state");

	a_issue_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bia_pkg::S_SCAN) |-> (iss_q <= act + bia_pkg::WORDS_W'(1)))
		else $error("scan issued more words than are in use");

	a_scan_write_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == bia_pkg::S_SCAN) |=> (state_q == bia_pkg::S_OUT))
		else $error("allocate wrote the map without finishing");

	a_range_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != bia_pkg::ST_OK) |-> !bit_value_q)
		else $error("error result carries a set bit value");

endmodule

### hdl/bia_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
